@@ sv/utf8vd_pkg.sv @@
`default_nettype none
package utf8vd_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OUT_OFFSET_W = 32;

  localparam logic [7:0] CONT_MASK    = 8'hc0;
  localparam logic [7:0] CONT_MARK    = 8'h80;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3f;
  localparam logic [7:0] LEAD2_LOW    = 8'hc2;
  localparam logic [7:0] LEAD2_HIGH   = 8'hdf;
  localparam logic [7:0] LEAD4_HIGH   = 8'hf4;

  localparam logic [20:0] MIN2       = 21'h80;
  localparam logic [20:0] MIN3       = 21'h800;
  localparam logic [20:0] MIN4       = 21'h10000;
  localparam logic [20:0] SCALAR_MAX = 21'h10ffff;
  localparam logic [20:0] SURR_LOW   = 21'hd800;
  localparam logic [20:0] SURR_HIGH  = 21'hdfff;

  typedef enum logic [2:0] {
    KIND_SCALAR     = 3'd0,
    KIND_UNEXP_CONT = 3'd1,
    KIND_BAD_LEAD   = 3'd2,
    KIND_TRUNCATED  = 3'd3,
    KIND_BAD_CONT   = 3'd4,
    KIND_OVERLONG   = 3'd5,
    KIND_RANGE      = 3'd6,
    KIND_SURROGATE  = 3'd7
  } kind_t;

  typedef logic [3:0][7:0] byte4_t;

  typedef struct packed {
    logic        stop;
    kind_t       kind;
    logic [20:0] scalar;
    logic [2:0]  drop;
    logic [2:0]  length;
  } scan_res_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_MARK;
  endfunction

endpackage
`default_nettype wire

@@ sv/utf8vd_scan.sv @@
`default_nettype none
module utf8vd_scan (
  input  utf8vd_pkg::byte4_t    bytes_i,
  input  logic [2:0]            count_i,
  input  logic                  final_i,
  output utf8vd_pkg::scan_res_t res_o
);
  import utf8vd_pkg::*;

  logic [7:0]  first;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic [2:0]  len;
  logic        lead_ok;
  logic        cont_ok;
  logic [20:0] value;
  logic [20:0] minimum;

  assign first = bytes_i[0];
  assign b1    = bytes_i[1] & CONT_PAYLOAD;
  assign b2    = bytes_i[2] & CONT_PAYLOAD;
  assign b3    = bytes_i[3] & CONT_PAYLOAD;

  // lead classification
  always_comb begin
    lead_ok = 1'b1;
    len     = 3'd1;
    minimum = '0;
    if (first inside {[8'h00:8'h7f]}) begin
      len     = 3'd1;
      minimum = '0;
    end else if (first inside {[LEAD2_LOW:LEAD2_HIGH]}) begin
      len     = 3'd2;
      minimum = MIN2;
    end else if (first inside {[8'he0:8'hef]}) begin
      len     = 3'd3;
      minimum = MIN3;
    end else if (first inside {[8'hf0:LEAD4_HIGH]}) begin
      len     = 3'd4;
      minimum = MIN4;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    case (len)
      3'd1:    value = {14'd0, first[6:0]};
      3'd2:    value = {10'd0, first[4:0], b1[5:0]};
      3'd3:    value = {5'd0, first[3:0], b1[5:0], b2[5:0]};
      default: value = {first[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
  end

  assign cont_ok = (len < 3'd2 || is_cont(bytes_i[1]))
                && (len < 3'd3 || is_cont(bytes_i[2]))
                && (len < 3'd4 || is_cont(bytes_i[3]));

  always_comb begin
    res_o.stop   = 1'b0;
    res_o.kind   = KIND_SCALAR;
    res_o.scalar = '0;
    res_o.drop   = 3'd1;
    res_o.length = 3'd0;
    if (count_i == 3'd0) begin
      res_o.stop = 1'b1;
    end else if (!lead_ok) begin
      res_o.kind = is_cont(first) ? KIND_UNEXP_CONT : KIND_BAD_LEAD;
    end else if (count_i < len) begin
      if (final_i) begin
        res_o.kind = KIND_TRUNCATED;
      end else begin
        res_o.stop = 1'b1;
      end
    end else if (!cont_ok) begin
      res_o.kind = KIND_BAD_CONT;
    end else if (value < minimum) begin
      res_o.kind = KIND_OVERLONG;
    end else if (value > SCALAR_MAX) begin
      res_o.kind = KIND_RANGE;
    end else if (value >= SURR_LOW && value <= SURR_HIGH) begin
      res_o.kind = KIND_SURROGATE;
    end else begin
      res_o.scalar = value;
      res_o.drop   = len;
      res_o.length = len;
    end
  end

endmodule
`default_nettype wire

@@ sv/utf8_validating_decoder_unit.sv @@
// Streaming UTF-8 decoder with strict validation.
// Input channel: one stream byte per request, in_end_of_input set on the
// stream's last byte. Result channel: one scalar or diagnostic per request
// with its kind, code point, offset and length; out_last_of_run marks
// the last result caused by an input byte. A byte that only extends a
// pending sequence causes no result.
// Path: an accepted byte is written into the held-byte buffer, the scan
// stage decodes it and the result is registered in the output register.
// Throughput: one input byte per cycle while in_stall is low. A byte causing
// k results (k up to 4) keeps the scan stage busy, one result per cycle
// from the held-byte buffer while out_stall allows; in_stall is high before
// the last result and the next byte is taken in the cycle of that result.
// When out_stall is high the output register holds its request and the
// scan stage waits with in_stall high; a byte is still taken while the
// scan stage has no result to deliver.
// Reset (synchronous, rst_n low) empties the held bytes, zeroes the byte
// offset and drops any undelivered result.
`default_nettype none
module utf8_validating_decoder_unit (
  input  wire  logic        clk,
  input  wire  logic        rst_n,
  input  wire  logic        in_valid,
  output logic              in_stall,
  input  wire  logic [7:0]  in_byte_value,
  input  wire  logic        in_end_of_input,
  output logic              out_valid,
  input  wire  logic        out_stall,
  output logic [2:0]        out_kind,
  output logic [20:0]       out_scalar,
  output logic [31:0]       out_offset,
  output logic [2:0]        out_length,
  output logic              out_last_of_run
);
  import utf8vd_pkg::*;

  byte4_t                   hold_r;
  logic [2:0]               count_r;
  logic                     fin_r;
  logic                     pending_r;
  logic [OFFSET_BITS-1:0]   pos_r;

  byte4_t                   hold_nxt;
  logic [2:0]               count_nxt;
  logic                     fin_nxt;
  logic                     pending_nxt;
  logic [OFFSET_BITS-1:0]   pos_nxt;

  logic                     out_valid_r;
  kind_t                    kind_r;
  logic [20:0]              scalar_r;
  logic [OFFSET_BITS-1:0]   offset_r;
  logic [2:0]               length_r;
  logic                     last_r;

  scan_res_t                res0;
  scan_res_t                res1;
  byte4_t                   shift_bytes;
  logic [2:0]               shift_count;
  logic                     busy;
  logic                     clear_now;
  logic                     out_free;
  logic                     fire;
  logic                     in_acc;
  byte4_t                   kept_bytes;
  logic [2:0]               kept_count;
  logic [OFFSET_BITS-1:0]   kept_pos;
  logic [1:0]               base_count;
  logic [OFFSET_BITS-1:0]   base_pos;

  utf8vd_scan u_scan_head (
    .bytes_i (hold_r),
    .count_i (count_r),
    .final_i (fin_r),
    .res_o   (res0)
  );

  // look ahead on the shifted buffer to flag the last result of a run
  utf8vd_scan u_scan_next (
    .bytes_i (shift_bytes),
    .count_i (shift_count),
    .final_i (fin_r),
    .res_o   (res1)
  );

  always_comb begin
    shift_bytes = hold_r;
    case (res0.drop)
      3'd1: begin
        shift_bytes[0] = hold_r[1];
        shift_bytes[1] = hold_r[2];
        shift_bytes[2] = hold_r[3];
      end
      3'd2: begin
        shift_bytes[0] = hold_r[2];
        shift_bytes[1] = hold_r[3];
      end
      3'd3: begin
        shift_bytes[0] = hold_r[3];
      end
      default: begin
        shift_bytes = hold_r;
      end
    endcase
  end

  assign shift_count = count_r - res0.drop;

  assign busy       = pending_r && !res0.stop;
  assign clear_now  = pending_r && fin_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign fire       = busy && out_free;
  // the next byte may join in the cycle of the last result of a run
  assign in_stall   = busy && !(out_free && res1.stop);
  assign in_acc     = in_valid && !in_stall;
  assign kept_bytes = fire ? shift_bytes : hold_r;
  assign kept_count = fire ? shift_count : count_r;
  assign kept_pos   = fire ? pos_r + OFFSET_BITS'(res0.drop) : pos_r;
  assign base_count = clear_now ? 2'd0 : kept_count[1:0];
  assign base_pos   = clear_now ? '0 : kept_pos;

  always_comb begin
    hold_nxt    = kept_bytes;
    count_nxt   = kept_count;
    fin_nxt     = fin_r;
    pending_nxt = pending_r;
    pos_nxt     = kept_pos;
    if (in_acc) begin
      case (base_count)
        2'd0:    hold_nxt[0] = in_byte_value;
        2'd1:    hold_nxt[1] = in_byte_value;
        2'd2:    hold_nxt[2] = in_byte_value;
        default: hold_nxt[3] = in_byte_value;
      endcase
      count_nxt   = {1'b0, base_count} + 3'd1;
      fin_nxt     = in_end_of_input;
      pending_nxt = 1'b1;
      pos_nxt     = base_pos;
    end else if (pending_r && res0.stop) begin
      pending_nxt = 1'b0;
      if (fin_r) begin
        count_nxt = 3'd0;
        pos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 3'd0;
      fin_r       <= 1'b0;
      pending_r   <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      fin_r     <= fin_nxt;
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (fire) begin
      kind_r   <= res0.kind;
      scalar_r <= res0.scalar;
      offset_r <= pos_r;
      length_r <= res0.length;
      last_r   <= res1.stop;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_scalar      = scalar_r;
  assign out_offset      = OUT_OFFSET_W'(offset_r);
  assign out_length      = length_r;
  assign out_last_of_run = last_r;

endmodule
`default_nettype wire

@@ bench/utf8_decode_checker.sv @@
module utf8_decode_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_end_of_input,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_kind,
  input  wire logic [20:0] out_scalar,
  input  wire logic [31:0] out_offset,
  input  wire logic [2:0]  out_length,
  input  wire logic        out_last_of_run,
  output int               mismatches,
  output int               awaiting,
  output int               results_checked,
  output logic [7:0]       kinds_seen
);
  import utf8vd_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [20:0] scalar;
    logic [31:0] offset;
    logic [2:0]  length;
    logic        last;
  } decoded_t;

  decoded_t    awaited_results [$];
  decoded_t    want;
  logic [7:0]  held [3];
  int          held_n = 0;
  logic [31:0] lead_at = '0;
  int          errors = 0;

  assign mismatches = errors;

  initial begin
    awaiting = 0;
    results_checked = 0;
    kinds_seen = '0;
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // one stream byte: emit every result it resolves, keep the short tail
  function automatic void decode_step(input logic [7:0] b, input logic fin);
    logic [7:0]  win [4];
    decoded_t    res [4];
    logic [31:0] pos;
    logic [20:0] cp;
    logic [20:0] floor_cp;
    kind_t       k;
    int          n;
    int          len;
    int          drop;
    int          cnt;
    logic        stop;
    for (int i = 0; i < 4; i++) win[i] = '0;
    for (int i = 0; i < held_n; i++) win[i] = held[i];
    win[held_n] = b;
    n = held_n + 1;
    pos = lead_at;
    cnt = 0;
    stop = 1'b0;
    while (n > 0 && !stop) begin
      drop = 1;
      len = 0;
      cp = '0;
      floor_cp = '0;
      k = KIND_SCALAR;
      if (win[0] <= 8'h7f) begin
        len = 1;
        cp = 21'(win[0]);
      end else if (win[0] >= LEAD2_LOW && win[0] <= LEAD2_HIGH) begin
        len = 2;
        cp = 21'(win[0][4:0]);
        floor_cp = MIN2;
      end else if (win[0][7:4] == 4'he) begin
        len = 3;
        cp = 21'(win[0][3:0]);
        floor_cp = MIN3;
      end else if (win[0] >= 8'hf0 && win[0] <= LEAD4_HIGH) begin
        len = 4;
        cp = 21'(win[0][2:0]);
        floor_cp = MIN4;
      end
      if (len == 0) begin
        k = ((win[0] & CONT_MASK) == CONT_MARK) ? KIND_UNEXP_CONT : KIND_BAD_LEAD;
      end else if (n < len) begin
        if (!fin) stop = 1'b1;
        k = KIND_TRUNCATED;
      end else begin
        for (int i = 1; i < len; i++) begin
          if ((win[i] & CONT_MASK) != CONT_MARK) k = KIND_BAD_CONT;
          cp = {cp[14:0], win[i][5:0]};
        end
        if (k == KIND_SCALAR) begin
          if (cp < floor_cp) k = KIND_OVERLONG;
          else if (cp > SCALAR_MAX) k = KIND_RANGE;
          else if (cp >= SURR_LOW && cp <= SURR_HIGH) k = KIND_SURROGATE;
          else drop = len;
        end
      end
      if (!stop) begin
        res[cnt].kind = k;
        res[cnt].scalar = (k == KIND_SCALAR) ? cp : '0;
        res[cnt].offset = pos;
        res[cnt].length = (k == KIND_SCALAR) ? 3'(len) : 3'd0;
        res[cnt].last = 1'b0;
        cnt++;
        for (int i = 0; i < 4; i++) begin
          if (i + drop < 4) win[i] = win[i + drop];
        end
        n -= drop;
        pos += 32'(drop);
      end
    end
    if (fin) begin
      held_n = 0;
      lead_at = '0;
    end else begin
      for (int i = 0; i < n; i++) held[i] = win[i];
      held_n = n;
      lead_at = pos;
    end
    if (cnt > 0) res[cnt - 1].last = 1'b1;
    for (int i = 0; i < cnt; i++) awaited_results.insert(awaited_results.size(), res[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      held_n = 0;
      lead_at = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d scalar %0h offset %0h",
                   $time, out_kind, out_scalar, out_offset);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("scalar", 32'(want.scalar), 32'(out_scalar));
          check_field("offset", want.offset, out_offset);
          check_field("length", 32'(want.length), 32'(out_length));
          check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
          results_checked++;
          kinds_seen[out_kind] = 1'b1;
        end
      end
      if (in_valid && !in_stall) decode_step(in_byte_value, in_end_of_input);
    end
    awaiting = awaited_results.size();
  end

endmodule

@@ bench/utf8_validating_decoder_unit_tb.sv @@
module utf8_validating_decoder_unit_tb;
  import utf8vd_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 245;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte_value = '0;
  logic        in_end_of_input = 1'b0;
  logic        out_stall = 1'b0;
  wire logic   in_stall;
  wire logic   out_valid;
  wire logic [2:0]  out_kind;
  wire logic [20:0] out_scalar;
  wire logic [31:0] out_offset;
  wire logic [2:0]  out_length;
  wire logic        out_last_of_run;

  int         fail_count;
  int         awaiting;
  int         results_checked;
  logic [7:0] kinds_seen;
  logic       gaps_on = 1'b1;
  int         quiet_cycles = 0;
  int         bytes_sent = 0;
  int         streams_sent = 0;
  logic [7:0] stream_bytes [$];

  utf8_validating_decoder_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_scalar      (out_scalar),
    .out_offset      (out_offset),
    .out_length      (out_length),
    .out_last_of_run (out_last_of_run)
  );

  utf8_decode_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_scalar      (out_scalar),
    .out_offset      (out_offset),
    .out_length      (out_length),
    .out_last_of_run (out_last_of_run),
    .mismatches      (fail_count),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .kinds_seen      (kinds_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 38);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no progress for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (gaps_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= b;
    in_end_of_input <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++) begin
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    end
    stream_bytes.delete();
    streams_sent++;
  endtask

  function automatic void put_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
  endfunction

  // mostly well-formed sequences, some noise, truncation, corruption and invalid forms
  function automatic void add_sequence();
    int          sel;
    int          len;
    int          start;
    logic [20:0] cp;
    sel = $urandom_range(99);
    if (sel >= 70 && sel < 78) begin
      put_byte(8'($urandom_range(255)));
      return;
    end
    len = $urandom_range(4, 1);
    case (len)
      1: cp = 21'($urandom_range('h7f));
      2: cp = 21'($urandom_range('h7ff, 'h80));
      3: cp = 21'($urandom_range('hffff, 'h800));
      default: cp = 21'($urandom_range('h10ffff, 'h10000));
    endcase
    if (len == 3 && cp >= SURR_LOW && cp <= SURR_HIGH) cp ^= 21'h2000;
    if (sel >= 90 && sel < 94) begin
      if (len == 4) cp = 21'($urandom_range('hffff));
      else len++;
    end else if (sel >= 94 && sel < 97) begin
      len = 3;
      cp = 21'($urandom_range('hdfff, 'hd800));
    end else if (sel >= 97) begin
      len = 4;
      cp = 21'($urandom_range('h1fffff, 'h110000));
    end
    start = stream_bytes.size();
    case (len)
      1: put_byte({1'b0, cp[6:0]});
      2: put_byte({3'b110, cp[10:6]});
      3: put_byte({4'b1110, cp[15:12]});
      default: put_byte({5'b11110, cp[20:18]});
    endcase
    for (int i = len - 2; i >= 0; i--) begin
      put_byte(CONT_MARK | 8'((cp >> (6 * i)) & 21'h3f));
    end
    if (len > 1 && sel >= 78 && sel < 84) begin
      repeat ($urandom_range(len - 1, 1)) void'(stream_bytes.pop_back());
    end else if (len > 1 && sel >= 84 && sel < 90) begin
      stream_bytes[start + $urandom_range(len - 1, 1)] = 8'($urandom_range(255));
    end
  endfunction

  initial begin
    int n_units;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ascii ends, widest scalars, surrogate, out of range, bad leads, stray
    // continuation, overlong, bad continuation, truncation at stream end
    stream_bytes = '{8'h00, 8'h7f, 8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
                     8'hed, 8'ha0, 8'h80, 8'hf4, 8'h90, 8'h80, 8'h80, 8'hc0,
                     8'hff, 8'h80, 8'he0, 8'h80, 8'h80, 8'hc2, 8'h41, 8'he1,
                     8'h41};
    send_stream();

    while (bytes_sent < 25 + RANDOM_BYTES) begin
      gaps_on <= !(bytes_sent >= 100 && bytes_sent < 170);
      n_units = $urandom_range(10, 1);
      repeat (n_units) add_sequence();
      send_stream();
    end
    in_valid <= 1'b0;
    in_end_of_input <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d streams, checked %0d results",
             bytes_sent, streams_sent, results_checked);
    $display("result kinds observed, one bit per kind: %b", kinds_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
